// File: hw/rtl/post_frame_parser_checker_defines.svh
// Assertion macros for the post frame parser and checker.
`ifndef POST_FRAME_PARSER_CHECKER_DEFINES_SVH
`define POST_FRAME_PARSER_CHECKER_DEFINES_SVH
`ifndef SYNTHESIS
`define PFPC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pfpc assertion failed");
`define PFPC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("pfpc assertion failed");
`else
`define PFPC_ASSERT(name, clk, rst_n, prop)
`define PFPC_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// File: hw/rtl/pfpc_pkg.sv
// Types and constants shared by the post frame parser and checker.
package pfpc_pkg;

  localparam int unsigned FrameCountLimitDef = 8191;
  localparam int unsigned QueueDepthDef      = 2;

  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned FrameW = 13;
  localparam int unsigned LenW   = 8;
  localparam int unsigned SizeW  = 14;

  localparam logic [SizeW-1:0] SizeSat = 14'd8192;

  localparam int unsigned FixedBytes  = 44;
  localparam int unsigned SenderStart = 17;
  localparam int unsigned SeqStart    = 33;
  localparam int unsigned LenStart    = 41;
  localparam int unsigned IdBytes     = 16;
  localparam int unsigned TimeBytes   = 8;

  localparam logic [LenW-1:0] FlagReply = 8'h01;
  localparam logic [LenW-1:0] FlagTime  = 8'h02;

  localparam logic [FrameW-1:0] MinFrameRst   = 13'd44;
  localparam logic [FrameW-1:0] MaxFrameRst   = 13'd4658;
  localparam logic [LenW-1:0]   MaxLenRst     = 8'd255;

  typedef enum logic [3:0] {
    SecFlags    = 4'd0,
    SecMsgId    = 4'd1,
    SecSenderId = 4'd2,
    SecSeq      = 4'd3,
    SecUidLen   = 4'd4,
    SecBodyLen  = 4'd5,
    SecMcount   = 4'd6,
    SecUid      = 4'd7,
    SecBody     = 4'd8,
    SecMention  = 4'd9,
    SecReply    = 4'd10,
    SecTime     = 4'd11,
    SecExcess   = 4'd12
  } section_e;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusSize   = 2'd1,
    StatusFlags  = 2'd2,
    StatusLength = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RegMinFrame   = 3'd0,
    RegMaxFrame   = 3'd1,
    RegMaxUid     = 3'd2,
    RegMaxBody    = 3'd3,
    RegMaxMention = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [FrameW-1:0] min_frame;
    logic [FrameW-1:0] max_frame;
    logic [LenW-1:0]   max_uid;
    logic [LenW-1:0]   max_body;
    logic [LenW-1:0]   max_mention;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       data;
    section_e         section;
    logic [7:0]       offset;
    logic [7:0]       midx;
    logic             last;
    logic [SizeW-1:0] size;
    logic [LenW-1:0]  flags;
    logic [LenW-1:0]  uid_len;
    logic [LenW-1:0]  body_len;
    logic [LenW-1:0]  mcount;
  } item_t;

endpackage

// File: hw/rtl/post_frame_parser_checker.sv
// Top level of the post frame parser and checker.
//
// Input channel: frame bytes with a last-byte mark; a byte is taken at an edge
// with push high and full low. Result channel: one tagged byte per input byte;
// the oldest result is shown while empty is low and taken at an edge with pop
// high and empty low. Each result carries the byte, its section and offset, the
// mention index, a done mark on the frame's last byte and the frame status there.
// Throughput is one byte per cycle unless full or a result waiting for pop holds
// the flow, set by the combinational tagging step in the front end and the single
// result register in the back end. The accepting edge writes the tag queue; the
// result register loads from it once free, and the result is then on the ports.
// When the receiver stalls, the result register holds and the tag queue fills;
// full rises once it holds QueueDepth tagged bytes behind the waiting result.
// Reset clears the byte counter, the captured header fields and the queue,
// empties the result register, and loads the limit registers with their defaults.
// The limit registers sit on an APB port with pready tied high; write them only
// while no frame is in flight.
module post_frame_parser_checker #(
  parameter int unsigned FrameCountLimit = pfpc_pkg::FrameCountLimitDef,
  parameter int unsigned QueueDepth      = pfpc_pkg::QueueDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pfpc_pkg::AddrW-1:0] paddr,
  input  logic [pfpc_pkg::DataW-1:0] pwdata,
  output logic [pfpc_pkg::DataW-1:0] prdata,
  output logic                       pready,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 frame_byte_i,
  input  logic                       is_last_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 byte_out_o,
  output logic [3:0]                 section_o,
  output logic [7:0]                 section_offset_o,
  output logic [7:0]                 mention_index_o,
  output logic                       frame_done_o,
  output logic [1:0]                 status_o
);
  import pfpc_pkg::*;

  `include "post_frame_parser_checker_defines.svh"

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [2:0] reg_idx;
  logic       accept;
  item_t      front_item, q_item;
  logic       q_empty, q_pop;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_frame   <= MinFrameRst;
      cfg_q.max_frame   <= MaxFrameRst;
      cfg_q.max_uid     <= MaxLenRst;
      cfg_q.max_body    <= MaxLenRst;
      cfg_q.max_mention <= MaxLenRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegMinFrame:   cfg_q.min_frame   <= pwdata[FrameW-1:0];
        RegMaxFrame:   cfg_q.max_frame   <= pwdata[FrameW-1:0];
        RegMaxUid:     cfg_q.max_uid     <= pwdata[LenW-1:0];
        RegMaxBody:    cfg_q.max_body    <= pwdata[LenW-1:0];
        RegMaxMention: cfg_q.max_mention <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegMinFrame:   prdata = DataW'(cfg_q.min_frame);
      RegMaxFrame:   prdata = DataW'(cfg_q.max_frame);
      RegMaxUid:     prdata = DataW'(cfg_q.max_uid);
      RegMaxBody:    prdata = DataW'(cfg_q.max_body);
      RegMaxMention: prdata = DataW'(cfg_q.max_mention);
      default:       prdata = '0;
    endcase
  end

  assign accept = push && !full;

  pfpc_front #(
    .FrameCountLimit(FrameCountLimit)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .frame_byte_i(frame_byte_i),
    .is_last_i   (is_last_i),
    .item_o      (front_item)
  );

  pfpc_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (accept),
    .wr_data_i(front_item),
    .full_o   (full),
    .rd_en_i  (q_pop),
    .rd_data_o(q_item),
    .empty_o  (q_empty)
  );

  pfpc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_empty_i       (q_empty),
    .q_data_i        (q_item),
    .q_pop_o         (q_pop),
    .byte_out_o      (byte_out_o),
    .section_o       (section_o),
    .section_offset_o(section_offset_o),
    .mention_index_o (mention_index_o),
    .frame_done_o    (frame_done_o),
    .status_o        (status_o),
    .empty           (empty),
    .pop             (pop)
  );

  `PFPC_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> empty)
  `PFPC_ASSERT(a_status_on_done, clk_i, rst_ni, !empty && (status_o != StatusOk) |-> frame_done_o)
  `PFPC_ASSERT(a_midx_mention, clk_i, rst_ni, !empty && (section_o != SecMention) |-> mention_index_o == '0)
  `PFPC_ASSERT(a_fixed_offset, clk_i, rst_ni, !empty && (section_o == SecFlags || section_o == SecUidLen || section_o == SecBodyLen || section_o == SecMcount) |-> section_offset_o == '0)

endmodule

// File: hw/rtl/pfpc_front.sv
// Front end: byte counter, header capture and section tagging.
module pfpc_front #(
  parameter int unsigned FrameCountLimit = pfpc_pkg::FrameCountLimitDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      frame_byte_i,
  input  logic            is_last_i,
  output pfpc_pkg::item_t item_o
);
  import pfpc_pkg::*;

  localparam int unsigned CntW = $clog2(FrameCountLimit + 1);
  localparam logic [CntW-1:0] CntMax    = CntW'(FrameCountLimit);
  localparam logic [CntW-1:0] PosSender = CntW'(SenderStart);
  localparam logic [CntW-1:0] PosSeq    = CntW'(SeqStart);
  localparam logic [CntW-1:0] PosUid    = CntW'(LenStart);
  localparam logic [CntW-1:0] PosBody   = CntW'(LenStart + 1);
  localparam logic [CntW-1:0] PosMcount = CntW'(LenStart + 2);
  localparam logic [CntW-1:0] PosFixed  = CntW'(FixedBytes);
  localparam logic [CntW:0]   SizeSatW  = (CntW + 1)'(SizeSat);
  localparam logic [7:0]      IdLen     = 8'(IdBytes);
  localparam logic [7:0]      TimeLen   = 8'(TimeBytes);
  localparam logic [3:0]      IdLast    = 4'(IdBytes - 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] flags_q, flags_d, uid_q, uid_d, body_q, body_d, mcount_q, mcount_d;
  section_e        wsec_q, wsec_d;
  logic [7:0]      woff_q, woff_d, wmidx_q, wmidx_d;

  logic            reply_en, time_en, stay;
  section_e        eff_sec, sec;
  logic [7:0]      off, midx;
  logic [CntW:0]   size_wide;
  logic [SizeW-1:0] size;

  assign reply_en = (flags_q & FlagReply) != '0;
  assign time_en  = (flags_q & FlagTime) != '0;

  always_comb begin
    stay = ((wsec_q == SecUid) && (woff_q < uid_q)) ||
           ((wsec_q == SecBody) && (woff_q < body_q)) ||
           ((wsec_q == SecMention) && (wmidx_q < mcount_q)) ||
           ((wsec_q == SecReply) && reply_en && (woff_q < IdLen)) ||
           ((wsec_q == SecTime) && time_en && (woff_q < TimeLen)) ||
           (wsec_q == SecExcess);
    if (stay) begin
      eff_sec = wsec_q;
    end else if ((wsec_q < SecBody) && (body_q != '0)) begin
      eff_sec = SecBody;
    end else if ((wsec_q < SecMention) && (mcount_q != '0)) begin
      eff_sec = SecMention;
    end else if ((wsec_q < SecReply) && reply_en) begin
      eff_sec = SecReply;
    end else if ((wsec_q < SecTime) && time_en) begin
      eff_sec = SecTime;
    end else begin
      eff_sec = SecExcess;
    end
  end

  always_comb begin
    off  = '0;
    midx = '0;
    if (cnt_q == '0) begin
      sec = SecFlags;
    end else if (cnt_q < PosSender) begin
      sec = SecMsgId;
      off = 8'(cnt_q - CntW'(1));
    end else if (cnt_q < PosSeq) begin
      sec = SecSenderId;
      off = 8'(cnt_q - PosSender);
    end else if (cnt_q < PosUid) begin
      sec = SecSeq;
      off = 8'(cnt_q - PosSeq);
    end else if (cnt_q == PosUid) begin
      sec = SecUidLen;
    end else if (cnt_q == PosBody) begin
      sec = SecBodyLen;
    end else if (cnt_q == PosMcount) begin
      sec = SecMcount;
    end else begin
      sec = eff_sec;
      if (stay) begin
        off = woff_q;
        if (eff_sec == SecMention) begin
          midx = wmidx_q;
        end
      end
    end
  end

  assign size_wide = {1'b0, cnt_q} + (CntW + 1)'(1);
  assign size      = (size_wide > SizeSatW) ? SizeSat : size_wide[SizeW-1:0];

  always_comb begin
    cnt_d    = cnt_q;
    flags_d  = flags_q;
    uid_d    = uid_q;
    body_d   = body_q;
    mcount_d = mcount_q;
    wsec_d   = wsec_q;
    woff_d   = woff_q;
    wmidx_d  = wmidx_q;
    if (cnt_q == '0) flags_d = frame_byte_i;
    if (cnt_q == PosUid) uid_d = frame_byte_i;
    if (cnt_q == PosBody) body_d = frame_byte_i;
    if (cnt_q == PosMcount) mcount_d = frame_byte_i;
    if (cnt_q < CntMax) cnt_d = cnt_q + CntW'(1);
    if ((cnt_q >= PosFixed) && (cnt_q != CntMax)) begin
      if (stay) begin
        if (wsec_q == SecMention) begin
          if (woff_q[3:0] == IdLast) begin
            woff_d  = '0;
            wmidx_d = wmidx_q + 8'd1;
          end else begin
            woff_d = woff_q + 8'd1;
          end
        end else if (woff_q != 8'hFF) begin
          woff_d = woff_q + 8'd1;
        end
      end else begin
        wsec_d  = eff_sec;
        woff_d  = 8'd1;
        wmidx_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      flags_q  <= '0;
      uid_q    <= '0;
      body_q   <= '0;
      mcount_q <= '0;
      wsec_q   <= SecUid;
      woff_q   <= '0;
      wmidx_q  <= '0;
    end else if (accept_i) begin
      if (is_last_i) begin
        cnt_q    <= '0;
        flags_q  <= '0;
        uid_q    <= '0;
        body_q   <= '0;
        mcount_q <= '0;
        wsec_q   <= SecUid;
        woff_q   <= '0;
        wmidx_q  <= '0;
      end else begin
        cnt_q    <= cnt_d;
        flags_q  <= flags_d;
        uid_q    <= uid_d;
        body_q   <= body_d;
        mcount_q <= mcount_d;
        wsec_q   <= wsec_d;
        woff_q   <= woff_d;
        wmidx_q  <= wmidx_d;
      end
    end
  end

  always_comb begin
    item_o.data     = frame_byte_i;
    item_o.section  = sec;
    item_o.offset   = off;
    item_o.midx     = midx;
    item_o.last     = is_last_i;
    item_o.size     = size;
    item_o.flags    = flags_d;
    item_o.uid_len  = uid_d;
    item_o.body_len = body_d;
    item_o.mcount   = mcount_d;
  end

endmodule

// File: hw/rtl/pfpc_queue.sv
// Small queue of tagged bytes between the front and back ends.
module pfpc_queue #(
  parameter int unsigned Depth = pfpc_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  pfpc_pkg::item_t wr_data_i,
  output logic            full_o,
  input  logic            rd_en_i,
  output pfpc_pkg::item_t rd_data_o,
  output logic            empty_o
);
  import pfpc_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [PtrW:0]   CntFull = (PtrW + 1)'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntFull);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + (PtrW + 1)'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - (PtrW + 1)'(1);
      end
    end
  end

endmodule

// File: hw/rtl/pfpc_back.sv
// Back end: frame status check and the result register.
module pfpc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pfpc_pkg::cfg_t  cfg_i,
  input  logic            q_empty_i,
  input  pfpc_pkg::item_t q_data_i,
  output logic            q_pop_o,
  output logic [7:0]      byte_out_o,
  output logic [3:0]      section_o,
  output logic [7:0]      section_offset_o,
  output logic [7:0]      mention_index_o,
  output logic            frame_done_o,
  output logic [1:0]      status_o,
  output logic            empty,
  input  logic            pop
);
  import pfpc_pkg::*;

  localparam logic [SizeW-1:0] FixedSize = SizeW'(FixedBytes);
  localparam logic [SizeW-1:0] IdSize    = SizeW'(IdBytes);
  localparam logic [SizeW-1:0] TimeSize  = SizeW'(TimeBytes);

  logic             valid_q;
  logic [7:0]       byte_q, off_q, midx_q;
  section_e         sec_q;
  logic             done_q;
  status_e          status_q, status_d;
  logic             load;
  logic             size_bad, flags_bad, len_bad;
  logic [SizeW-1:0] expected;

  assign load    = !q_empty_i && (!valid_q || pop);
  assign q_pop_o = load;

  always_comb begin
    size_bad  = (q_data_i.size < FixedSize) ||
                (q_data_i.size < SizeW'(cfg_i.min_frame)) ||
                (q_data_i.size > SizeW'(cfg_i.max_frame));
    flags_bad = (q_data_i.flags & ~(FlagReply | FlagTime)) != '0;
    len_bad   = (q_data_i.uid_len > cfg_i.max_uid) ||
                (q_data_i.body_len > cfg_i.max_body) ||
                (q_data_i.mcount > cfg_i.max_mention);
    expected  = FixedSize + SizeW'(q_data_i.uid_len) + SizeW'(q_data_i.body_len) +
                {2'b00, q_data_i.mcount, 4'b0000} +
                (((q_data_i.flags & FlagReply) != '0) ? IdSize : '0) +
                (((q_data_i.flags & FlagTime) != '0) ? TimeSize : '0);
    if (!q_data_i.last) begin
      status_d = StatusOk;
    end else if (size_bad) begin
      status_d = StatusSize;
    end else if (flags_bad) begin
      status_d = StatusFlags;
    end else if (len_bad || (expected != q_data_i.size)) begin
      status_d = StatusLength;
    end else begin
      status_d = StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (pop) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= q_data_i.data;
      sec_q    <= q_data_i.section;
      off_q    <= q_data_i.offset;
      midx_q   <= q_data_i.midx;
      done_q   <= q_data_i.last;
      status_q <= status_d;
    end
  end

  assign empty            = !valid_q;
  assign byte_out_o       = byte_q;
  assign section_o        = sec_q;
  assign section_offset_o = off_q;
  assign mention_index_o  = midx_q;
  assign frame_done_o     = done_q;
  assign status_o         = status_q;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the post frame parser and checker: frames in, tagged bytes out.
module tb;
  import pfpc_pkg::*;

  typedef struct {
    logic [7:0] data;
    section_e   sec;
    logic [7:0] ofs;
    logic [7:0] midx;
    logic       done;
    status_e    st;
  } byte_tag_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             push;
  logic             full;
  logic [7:0]       frame_byte_i;
  logic             is_last_i;
  logic             empty;
  logic             pop = 1'b0;
  logic [7:0]       byte_out_o;
  logic [3:0]       section_o;
  logic [7:0]       section_offset_o;
  logic [7:0]       mention_index_o;
  logic             frame_done_o;
  logic [1:0]       status_o;

  cfg_t              limits;
  logic [FrameW-1:0] byte_cnt;
  logic [LenW-1:0]   flags_q;
  logic [LenW-1:0]   uid_len;
  logic [LenW-1:0]   body_len;
  logic [LenW-1:0]   mention_cnt;

  byte_tag_t   expected_tags[$];
  int          errors;
  int unsigned bytes_sent;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  post_frame_parser_checker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .push             (push),
    .full             (full),
    .frame_byte_i     (frame_byte_i),
    .is_last_i        (is_last_i),
    .empty            (empty),
    .pop              (pop),
    .byte_out_o       (byte_out_o),
    .section_o        (section_o),
    .section_offset_o (section_offset_o),
    .mention_index_o  (mention_index_o),
    .frame_done_o     (frame_done_o),
    .status_o         (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic byte_tag_t tag_frame_byte(input logic [7:0] b, input logic lst);
    byte_tag_t t;
    int p, q, uid_end, body_end, ment_end, reply_end, time_end, frame_size;
    p = int'(byte_cnt);
    if (p == 0) flags_q = b;
    else if (p == int'(LenStart)) uid_len = b;
    else if (p == int'(LenStart) + 1) body_len = b;
    else if (p == int'(LenStart) + 2) mention_cnt = b;
    q = p - int'(FixedBytes);
    uid_end = int'(uid_len);
    body_end = uid_end + int'(body_len);
    ment_end = body_end + int'(IdBytes) * int'(mention_cnt);
    reply_end = ment_end + (((flags_q & FlagReply) != '0) ? int'(IdBytes) : 0);
    time_end = reply_end + (((flags_q & FlagTime) != '0) ? int'(TimeBytes) : 0);
    t.data = b;
    t.ofs = '0;
    t.midx = '0;
    t.done = lst;
    t.st = StatusOk;
    if (p == 0) t.sec = SecFlags;
    else if (p < int'(SenderStart)) begin
      t.sec = SecMsgId;
      t.ofs = 8'(p - 1);
    end else if (p < int'(SeqStart)) begin
      t.sec = SecSenderId;
      t.ofs = 8'(p - int'(SenderStart));
    end else if (p < int'(LenStart)) begin
      t.sec = SecSeq;
      t.ofs = 8'(p - int'(SeqStart));
    end else if (p < int'(FixedBytes)) begin
      t.sec = section_e'(int'(SecUidLen) + p - int'(LenStart));
    end else if (q < uid_end) begin
      t.sec = SecUid;
      t.ofs = 8'(q);
    end else if (q < body_end) begin
      t.sec = SecBody;
      t.ofs = 8'(q - uid_end);
    end else if (q < ment_end) begin
      t.sec = SecMention;
      t.ofs = 8'((q - body_end) % int'(IdBytes));
      t.midx = 8'((q - body_end) / int'(IdBytes));
    end else if (q < reply_end) begin
      t.sec = SecReply;
      t.ofs = 8'(q - ment_end);
    end else if (q < time_end) begin
      t.sec = SecTime;
      t.ofs = 8'(q - reply_end);
    end else begin
      t.sec = SecExcess;
      t.ofs = (q - time_end > 255) ? 8'd255 : 8'(q - time_end);
    end
    if (int'(byte_cnt) < int'(FrameCountLimitDef)) byte_cnt = byte_cnt + 1'b1;
    if (lst) begin
      frame_size = p + 1;
      if (frame_size < int'(FixedBytes) || frame_size < int'(limits.min_frame) ||
          frame_size > int'(limits.max_frame)) begin
        t.st = StatusSize;
      end else if ((flags_q & ~(FlagReply | FlagTime)) != '0) begin
        t.st = StatusFlags;
      end else if (uid_len > limits.max_uid || body_len > limits.max_body ||
                   mention_cnt > limits.max_mention) begin
        t.st = StatusLength;
      end else if (frame_size != int'(FixedBytes) + time_end) begin
        t.st = StatusLength;
      end
      byte_cnt = '0;
      flags_q = '0;
      uid_len = '0;
      body_len = '0;
      mention_cnt = '0;
    end
    return t;
  endfunction

  function automatic int unsigned frame_len(input logic [7:0] flags, uid, body, mcount);
    return FixedBytes + uid + body + IdBytes * mcount +
           (((flags & FlagReply) != '0) ? IdBytes : 0) +
           (((flags & FlagTime) != '0) ? TimeBytes : 0);
  endfunction

  task automatic compare_field(input string name, input logic [DataW-1:0] exp_v, act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(negedge clk_i) pop <= ($urandom_range(0, 99) >= rx_idle_pct);

  always @(posedge clk_i) begin
    byte_tag_t e;
    if (rst_ni && pop && !empty) begin
      if (expected_tags.size() == 0) begin
        $error("result transaction with nothing pending");
        errors++;
      end else begin
        e = expected_tags.pop_front();
        compare_field("byte_out", e.data, byte_out_o);
        compare_field("section", e.sec, section_o);
        compare_field("section_offset", e.ofs, section_offset_o);
        compare_field("mention_index", e.midx, mention_index_o);
        compare_field("frame_done", e.done, frame_done_o);
        compare_field("status", e.st, status_o);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    frame_byte_i <= b;
    is_last_i <= lst;
    do @(posedge clk_i); while (full);
    expected_tags.insert(expected_tags.size(), tag_frame_byte(b, lst));
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] flags, uid, body, mcount,
                            input int unsigned len);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      case (i)
        0:            b = flags;
        LenStart:     b = uid;
        LenStart + 1: b = body;
        LenStart + 2: b = mcount;
        default:      b = 8'($urandom);
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk_i); while (expected_tags.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic check_reg(input reg_idx_e idx, input logic [DataW-1:0] val);
    logic [DataW-1:0] mask;
    mask = (idx == RegMinFrame || idx == RegMaxFrame) ? DataW'({FrameW{1'b1}}) :
                                                        DataW'({LenW{1'b1}});
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= AddrW'(4 * int'(idx));
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    compare_field(idx.name(), val & mask, prdata & mask);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(4 * int'(idx));
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegMinFrame:   limits.min_frame = val[FrameW-1:0];
      RegMaxFrame:   limits.max_frame = val[FrameW-1:0];
      RegMaxUid:     limits.max_uid = val[LenW-1:0];
      RegMaxBody:    limits.max_body = val[LenW-1:0];
      RegMaxMention: limits.max_mention = val[LenW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    check_reg(idx, val);
  endtask

  task automatic set_limits(input int unsigned min_f, max_f, max_u, max_b, max_m);
    wait_drained();
    write_reg(RegMinFrame, min_f);
    write_reg(RegMaxFrame, max_f);
    write_reg(RegMaxUid, max_u);
    write_reg(RegMaxBody, max_b);
    write_reg(RegMaxMention, max_m);
  endtask

  task automatic test_reset_values();
    check_reg(RegMinFrame, MinFrameRst);
    check_reg(RegMaxFrame, MaxFrameRst);
    check_reg(RegMaxUid, MaxLenRst);
    check_reg(RegMaxBody, MaxLenRst);
    check_reg(RegMaxMention, MaxLenRst);
  endtask

  task automatic test_all_sections();
    send_frame(FlagReply | FlagTime, 3, 2, 2, frame_len(FlagReply | FlagTime, 3, 2, 2));
  endtask

  task automatic test_status_codes();
    send_frame(0, 0, 0, 0, 1);
    send_frame(8'h84, 0, 0, 0, FixedBytes);
    send_frame(FlagTime, 1, 0, 0, frame_len(FlagTime, 1, 0, 0) + 2);
    send_frame(0, 0, 0, 0, FixedBytes);
  endtask

  task automatic test_limit_registers();
    set_limits(FixedBytes, 8191, 0, 0, 0);
    send_frame(0, 1, 0, 0, 45);
    send_frame(0, 0, 1, 0, 45);
    send_frame(0, 0, 0, 1, 60);
    send_frame(0, 0, 0, 0, FixedBytes);
    set_limits(FixedBytes, FixedBytes, 255, 255, 255);
    send_frame(0, 0, 0, 0, FixedBytes);
    send_frame(0, 0, 0, 0, FixedBytes + 1);
    set_limits(100, 50, 255, 255, 255);
    send_frame(0, 0, 0, 0, 60);
    set_limits(0, MaxFrameRst, 255, 255, 255);
    send_frame(0, 0, 0, 0, FixedBytes - 1);
    set_limits(MinFrameRst, MaxFrameRst, MaxLenRst, MaxLenRst, MaxLenRst);
  endtask

  task automatic test_random_frames(input int unsigned tx_pct, rx_pct, count);
    int unsigned stop_at, kind, len;
    logic [7:0] flags, uid, body, mcount;
    wait_drained();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    set_limits(($urandom_range(0, 3) == 0) ? FixedBytes : $urandom_range(44, 90),
               ($urandom_range(0, 2) == 0) ? 8191 : $urandom_range(60, 400),
               ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 12),
               ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 12),
               ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 4));
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      flags = (kind == 2) ? 8'($urandom) : 8'($urandom_range(0, 3));
      uid = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
      body = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
      mcount = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 20)) :
                                              8'($urandom_range(0, 2));
      len = frame_len(flags, uid, body, mcount);
      if (kind < 2) len = $urandom_range(1, FixedBytes - 1);
      else if (kind == 3) len = $urandom_range(FixedBytes, len + 20);
      send_frame(flags, uid, body, mcount, len);
    end
  endtask

  task automatic test_counter_saturation();
    set_limits(FixedBytes, 8191, 255, 255, 255);
    send_frame(0, 0, 0, 0, 8200);
    send_frame(FlagReply, 0, 1, 0, frame_len(FlagReply, 0, 1, 0));
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    push = 1'b0;
    frame_byte_i = '0;
    is_last_i = 1'b0;
    errors = 0;
    bytes_sent = 0;
    tx_idle_pct = 24;
    rx_idle_pct = 47;
    limits = '{MinFrameRst, MaxFrameRst, MaxLenRst, MaxLenRst, MaxLenRst};
    byte_cnt = '0;
    flags_q = '0;
    uid_len = '0;
    body_len = '0;
    mention_cnt = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_values();
    test_all_sections();
    test_status_codes();
    test_limit_registers();
    test_random_frames(24, 47, 150);
    test_random_frames(47, 24, 150);
    test_random_frames(0, 0, 150);
    test_counter_saturation();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && expected_tags.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
